// ===== src/ptzcf_pkg.sv =====
// ptzcf_pkg: shared types, codes and tables for the ptz camera command framer
// used by every module in src; no dependencies

package ptzcf_pkg;

   localparam int FRAME_LENGTH      = 7;
   localparam int QUEUE_DEPTH       = 2;
   localparam int IDX_W             = 3;

   localparam logic [7:0] HEADER_BYTE     = 8'hA5;
   localparam logic [7:0] TERM_BYTE       = 8'h55;
   localparam logic [7:0] CMD_MOVE        = 8'h10;
   localparam logic [7:0] CMD_PRESET_SET  = 8'h25;
   localparam logic [7:0] CMD_PRESET_GOTO = 8'h11;
   localparam logic [7:0] SUB_PANTILT     = 8'h0D;
   localparam logic [7:0] SUB_ZOOM_WIDE   = 8'h0C;
   localparam logic [7:0] SUB_ZOOM_TELE   = 8'h0E;
   localparam logic [7:0] SUB_IRIS_OPEN   = 8'h06;
   localparam logic [7:0] SUB_IRIS_CLOSE  = 8'h05;
   localparam logic [7:0] SUB_FOCUS_NEAR  = 8'h03;
   localparam logic [7:0] SUB_FOCUS_FAR   = 8'h04;
   localparam logic [7:0] DATA_IDLE       = 8'h88;
   localparam logic [3:0] NIB_PAN_LOW     = 4'h8;
   localparam logic [3:0] NIB_HIGH_SET    = 4'h8;
   localparam logic [7:0] PCT_MAX         = 8'd100;

   localparam logic [7:0] CAM_ADDR_RESET  = 8'd1;
   localparam logic [6:0] DFLT_PCT_RESET  = 7'd50;

   typedef enum logic [0:0] {
      REG_CAM_ADDR = 1'b0,
      REG_DFLT_PCT = 1'b1
   } reg_idx_type;

   typedef enum logic [4:0] {
      OP_PAN_LEFT    = 5'd0,
      OP_PAN_RIGHT   = 5'd1,
      OP_TILT_UP     = 5'd2,
      OP_TILT_DOWN   = 5'd3,
      OP_LEFT_UP     = 5'd4,
      OP_LEFT_DOWN   = 5'd5,
      OP_RIGHT_UP    = 5'd6,
      OP_RIGHT_DOWN  = 5'd7,
      OP_ZOOM_WIDE   = 5'd8,
      OP_ZOOM_TELE   = 5'd9,
      OP_IRIS_OPEN   = 5'd10,
      OP_IRIS_CLOSE  = 5'd11,
      OP_FOCUS_NEAR  = 5'd12,
      OP_FOCUS_FAR   = 5'd13,
      OP_STOP        = 5'd14,
      OP_PRESET_SET  = 5'd15,
      OP_PRESET_GOTO = 5'd16,
      OP_OSD_UP      = 5'd17,
      OP_OSD_DOWN    = 5'd18,
      OP_OSD_LEFT    = 5'd19,
      OP_OSD_RIGHT   = 5'd20,
      OP_OSD_ENTER   = 5'd21,
      OP_OSD_STOP    = 5'd22,
      OP_NONE        = 5'd23
   } op_type;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] cmd1;
      logic [7:0] cmd2;
      logic [7:0] data;
   } frame_desc_type;

   // smallest percentage reaching each speed index: ceil(100*k/7)
   localparam logic [7:0] SPEED_THRESH [1:6] = '{8'd15, 8'd29, 8'd43, 8'd58, 8'd72, 8'd86};

   localparam logic [3:0] LEFT_UP_NIB    [0:6] = '{4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};
   localparam logic [3:0] RIGHT_DOWN_NIB [0:6] = '{4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14,
                                                   4'd15};

   // 7*pct/100 saturated at 6
   function automatic logic [2:0] speed_index(input logic [7:0] pct);
      logic [2:0] idx;
      idx = 3'd0;
      for (int k = 1; k <= 6; k++) begin
         if (pct >= SPEED_THRESH[k]) begin
            idx = 3'(k);
         end
      end
      return idx;
   endfunction

   function automatic logic [7:0] pan_byte(input logic [3:0] n);
      return {n, NIB_PAN_LOW};
   endfunction

   function automatic logic [7:0] tilt_byte(input logic [3:0] n);
      return {NIB_HIGH_SET, n};
   endfunction

endpackage

// ===== src/ptz_camera_command_framer.sv =====
// ptz_camera_command_framer: top level with csr registers, front classifier,
// descriptor queue and frame serializer; depends on ptzcf_pkg and ptzcf_* modules
// path: a command beat passes the front descriptor register, the descriptor queue and the
// serializer output register; throughput: a framing command yields seven byte beats, one per cycle
//   while rsp_tready is high; non-framing commands are absorbed at one per cycle unless the queue is full
// reset: synchronous, clears handshake state, camera address 1, default speed 50 percent

module ptz_camera_command_framer #(
   parameter int QUEUE_DEPTH = ptzcf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // operation[4:0], command_param[12:5], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // frame_byte[7:0], byte_index[10:8], zero pad
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]                cam_addr_ff;
   logic [6:0]                dflt_pct_ff;
   logic                      csr_wr;
   ptzcf_pkg::reg_idx_type    csr_idx;
   logic                      fq_valid, fq_ready, qb_valid, qb_pop;
   ptzcf_pkg::frame_desc_type fq_desc, qb_desc;
   logic [7:0]                frame_byte;
   logic [2:0]                byte_index;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = ptzcf_pkg::reg_idx_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_idx)
         ptzcf_pkg::REG_CAM_ADDR: csr_prdata = {24'd0, cam_addr_ff};
         ptzcf_pkg::REG_DFLT_PCT: csr_prdata = {25'd0, dflt_pct_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_addr_ff <= ptzcf_pkg::CAM_ADDR_RESET;
         dflt_pct_ff <= ptzcf_pkg::DFLT_PCT_RESET;
      end else if (csr_wr) begin
         if (csr_idx == ptzcf_pkg::REG_CAM_ADDR) begin
            cam_addr_ff <= csr_pwdata[7:0];
         end else begin
            dflt_pct_ff <= csr_pwdata[6:0];
         end
      end
   end

   ptzcf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .operation     (req_tdata[4:0]),
      .command_param (req_tdata[12:5]),
      .cam_addr      (cam_addr_ff),
      .dflt_pct      (dflt_pct_ff),
      .desc_valid    (fq_valid),
      .desc_ready    (fq_ready),
      .desc          (fq_desc)
   );

   ptzcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_desc  (fq_desc),
      .pop_valid  (qb_valid),
      .pop        (qb_pop),
      .pop_desc   (qb_desc)
   );

   ptzcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (qb_valid),
      .desc       (qb_desc),
      .desc_pop   (qb_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .frame_byte (frame_byte),
      .byte_index (byte_index),
      .last_byte  (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, byte_index, frame_byte};

endmodule

// ===== src/ptzcf_front.sv =====
// ptzcf_front: accepts command beats, builds the three command bytes
// and drops non-framing operations; depends on ptzcf_pkg

module ptzcf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [4:0]               operation,
   input  logic [7:0]               command_param,
   input  logic [7:0]               cam_addr,
   input  logic [6:0]               dflt_pct,
   output logic                     desc_valid,
   input  logic                     desc_ready,
   output ptzcf_pkg::frame_desc_type desc
);

   logic                      valid_ff, valid_in;
   ptzcf_pkg::frame_desc_type desc_ff, desc_in;
   logic                      framing;
   logic [7:0]                pct;
   logic [2:0]                idx;
   logic [3:0]                lu, rd;
   logic                      accept;

   assign in_ready   = !valid_ff || desc_ready;
   assign accept     = in_valid && in_ready;
   assign desc_valid = valid_ff;
   assign desc       = desc_ff;

   always_comb begin
      pct = (command_param != 8'd0) ? command_param : {1'b0, dflt_pct};
      idx = ptzcf_pkg::speed_index(pct);
      lu  = ptzcf_pkg::LEFT_UP_NIB[idx];
      rd  = ptzcf_pkg::RIGHT_DOWN_NIB[idx];

      framing      = 1'b1;
      desc_in.addr = cam_addr;
      desc_in.cmd1 = ptzcf_pkg::CMD_MOVE;
      desc_in.cmd2 = ptzcf_pkg::SUB_PANTILT;
      desc_in.data = ptzcf_pkg::DATA_IDLE;

      unique case (operation) inside
         ptzcf_pkg::OP_PAN_LEFT:   desc_in.data = ptzcf_pkg::pan_byte(lu);
         ptzcf_pkg::OP_PAN_RIGHT:  desc_in.data = ptzcf_pkg::pan_byte(rd);
         ptzcf_pkg::OP_TILT_UP:    desc_in.data = ptzcf_pkg::tilt_byte(lu);
         ptzcf_pkg::OP_TILT_DOWN:  desc_in.data = ptzcf_pkg::tilt_byte(rd);
         ptzcf_pkg::OP_LEFT_UP:
            desc_in.data = ptzcf_pkg::pan_byte(lu) + ptzcf_pkg::tilt_byte(lu);
         ptzcf_pkg::OP_LEFT_DOWN:
            desc_in.data = ptzcf_pkg::pan_byte(lu) + ptzcf_pkg::tilt_byte(rd);
         ptzcf_pkg::OP_RIGHT_UP:
            desc_in.data = ptzcf_pkg::pan_byte(rd) + ptzcf_pkg::tilt_byte(lu);
         ptzcf_pkg::OP_RIGHT_DOWN:
            desc_in.data = ptzcf_pkg::pan_byte(rd) + ptzcf_pkg::tilt_byte(rd);
         ptzcf_pkg::OP_ZOOM_WIDE:  desc_in.cmd2 = ptzcf_pkg::SUB_ZOOM_WIDE;
         ptzcf_pkg::OP_ZOOM_TELE:  desc_in.cmd2 = ptzcf_pkg::SUB_ZOOM_TELE;
         ptzcf_pkg::OP_IRIS_OPEN:  desc_in.cmd2 = ptzcf_pkg::SUB_IRIS_OPEN;
         ptzcf_pkg::OP_IRIS_CLOSE: desc_in.cmd2 = ptzcf_pkg::SUB_IRIS_CLOSE;
         ptzcf_pkg::OP_FOCUS_NEAR: desc_in.cmd2 = ptzcf_pkg::SUB_FOCUS_NEAR;
         ptzcf_pkg::OP_FOCUS_FAR:  desc_in.cmd2 = ptzcf_pkg::SUB_FOCUS_FAR;
         ptzcf_pkg::OP_STOP: begin
         end
         ptzcf_pkg::OP_PRESET_SET, ptzcf_pkg::OP_PRESET_GOTO: begin
            desc_in.cmd1 = (operation == ptzcf_pkg::OP_PRESET_SET) ?
                           ptzcf_pkg::CMD_PRESET_SET : ptzcf_pkg::CMD_PRESET_GOTO;
            desc_in.cmd2 = {ptzcf_pkg::NIB_HIGH_SET, command_param[7:4]};
            desc_in.data = {ptzcf_pkg::NIB_HIGH_SET, command_param[3:0]};
         end
         [ptzcf_pkg::OP_OSD_UP:ptzcf_pkg::OP_OSD_STOP]: begin
            desc_in.cmd1 = 8'd0;
            desc_in.cmd2 = 8'd0;
            desc_in.data = 8'd0;
         end
         default: framing = 1'b0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = accept && framing;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

endmodule

// ===== src/ptzcf_queue.sv =====
// ptzcf_queue: short register queue of frame descriptors between front and back
// depends on ptzcf_pkg

module ptzcf_queue #(
   parameter int DEPTH = ptzcf_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  ptzcf_pkg::frame_desc_type push_desc,
   output logic                      pop_valid,
   input  logic                      pop,
   output ptzcf_pkg::frame_desc_type pop_desc
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ptzcf_pkg::frame_desc_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== src/ptzcf_back.sv =====
// ptzcf_back: serializes one descriptor into seven frame byte beats with a
// running checksum and an output register; depends on ptzcf_pkg

module ptzcf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      desc_valid,
   input  ptzcf_pkg::frame_desc_type desc,
   output logic                      desc_pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                frame_byte,
   output logic [2:0]                byte_index,
   output logic                      last_byte
);

   localparam logic [2:0] LAST_IDX = 3'(ptzcf_pkg::FRAME_LENGTH - 1);

   logic [2:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic [2:0] index_ff;
   logic       last_ff;
   logic [7:0] sel_byte;
   logic       load;

   assign load       = desc_valid && (!valid_ff || out_ready);
   assign desc_pop   = load && (pos_ff == LAST_IDX);
   assign out_valid  = valid_ff;
   assign frame_byte = byte_ff;
   assign byte_index = index_ff;
   assign last_byte  = last_ff;

   always_comb begin
      case (pos_ff)
         3'd0:    sel_byte = ptzcf_pkg::HEADER_BYTE;
         3'd1:    sel_byte = desc.addr;
         3'd2:    sel_byte = desc.cmd1;
         3'd3:    sel_byte = desc.cmd2;
         3'd4:    sel_byte = desc.data;
         3'd5:    sel_byte = ptzcf_pkg::TERM_BYTE;
         default: sel_byte = sum_ff;
      endcase
   end

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = (pos_ff == LAST_IDX) ? 3'd0 : pos_ff + 3'd1;
         sum_in   = (pos_ff == 3'd0) ? sel_byte : sum_ff + sel_byte;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      sum_ff <= sum_in;
      if (load) begin
         byte_ff  <= sel_byte;
         index_ff <= pos_ff;
         last_ff  <= (pos_ff == LAST_IDX);
      end
   end

endmodule

// ===== verif/ptz_camera_command_framer_test.sv =====
// ptz_camera_command_framer_test: self-checking bench for the ptz command framer,
// predicts every 7-byte frame from the command beat and the csr settings
// depends on ptzcf_pkg and the framer rtl in src

module ptz_camera_command_framer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          SETTLE_CYCLES  = 10;
   localparam logic [4:0]  OP_UNUSED_TOP  = 5'd31;

   typedef struct packed {
      logic [4:0] op;
      logic [7:0] param;
   } cmd_beat_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [2:0] byte_index;
      logic       last_byte;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // operation[4:0], command_param[12:5], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // frame_byte[7:0], byte_index[10:8], zero pad
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cmd_beat_type   pending_cmds[$];
   frame_beat_type frame_expect[$];

   logic [7:0]  cam_addr_cfg = ptzcf_pkg::CAM_ADDR_RESET;
   logic [6:0]  dflt_pct_cfg = ptzcf_pkg::DFLT_PCT_RESET;

   int          cmds_queued = 0;
   int          cmds_accepted = 0;
   int          beats_checked = 0;
   int          csr_writes = 0;
   int          mismatch_count = 0;
   bit          idle_on = 1'b1;
   int          hold_asks = 0;
   int          hold_taken = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   ptz_camera_command_framer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected frame for one accepted command under the current settings
   function automatic void build_frame(input logic [4:0] op, input logic [7:0] param);
      logic [7:0]     fb [0:6];
      logic [7:0]     pct;
      int unsigned    spd;
      logic [3:0]     lu;
      logic [3:0]     rd;
      logic [7:0]     sum;
      frame_beat_type b;
      if (op >= ptzcf_pkg::OP_NONE) return;
      pct = (param != 8'd0) ? param : {1'b0, dflt_pct_cfg};
      spd = (7 * pct) / 100;
      if (spd > 6) spd = 6;
      lu = 4'(7 - spd);
      rd = 4'(9 + spd);
      fb[0] = 8'hA5;
      fb[1] = cam_addr_cfg;
      fb[2] = 8'h10;
      fb[3] = 8'h0D;
      fb[4] = 8'h88;
      fb[5] = 8'h55;
      case (ptzcf_pkg::op_type'(op))
         ptzcf_pkg::OP_PAN_LEFT:    fb[4] = {lu, 4'h8};
         ptzcf_pkg::OP_PAN_RIGHT:   fb[4] = {rd, 4'h8};
         ptzcf_pkg::OP_TILT_UP:     fb[4] = {4'h8, lu};
         ptzcf_pkg::OP_TILT_DOWN:   fb[4] = {4'h8, rd};
         ptzcf_pkg::OP_LEFT_UP:     fb[4] = {lu, 4'h8} + {4'h8, lu};
         ptzcf_pkg::OP_LEFT_DOWN:   fb[4] = {lu, 4'h8} + {4'h8, rd};
         ptzcf_pkg::OP_RIGHT_UP:    fb[4] = {rd, 4'h8} + {4'h8, lu};
         ptzcf_pkg::OP_RIGHT_DOWN:  fb[4] = {rd, 4'h8} + {4'h8, rd};
         ptzcf_pkg::OP_ZOOM_WIDE:   fb[3] = 8'h0C;
         ptzcf_pkg::OP_ZOOM_TELE:   fb[3] = 8'h0E;
         ptzcf_pkg::OP_IRIS_OPEN:   fb[3] = 8'h06;
         ptzcf_pkg::OP_IRIS_CLOSE:  fb[3] = 8'h05;
         ptzcf_pkg::OP_FOCUS_NEAR:  fb[3] = 8'h03;
         ptzcf_pkg::OP_FOCUS_FAR:   fb[3] = 8'h04;
         ptzcf_pkg::OP_STOP:        ;
         ptzcf_pkg::OP_PRESET_SET, ptzcf_pkg::OP_PRESET_GOTO: begin
            fb[2] = (op == ptzcf_pkg::OP_PRESET_SET) ? 8'h25 : 8'h11;
            fb[3] = {4'h8, param[7:4]};
            fb[4] = {4'h8, param[3:0]};
         end
         default: begin
            fb[2] = 8'h00;
            fb[3] = 8'h00;
            fb[4] = 8'h00;
         end
      endcase
      sum = 8'h00;
      for (int k = 0; k < 6; k++) sum = sum + fb[k];
      fb[6] = sum;
      for (int k = 0; k < 7; k++) begin
         b.frame_byte = fb[k];
         b.byte_index = 3'(k);
         b.last_byte  = (k == 6);
         frame_expect.push_back(b);
      end
   endfunction

   // command driver
   always @(posedge clock) begin
      cmd_beat_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            build_frame(req_tdata[4:0], req_tdata[12:5]);
            cmds_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (idle_on && pending_cmds.size() != 0 && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 6);
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               c = pending_cmds.pop_front();
               req_tdata  <= {3'b000, c.param, c.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // frame monitor and receiver stalls
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (frame_expect.size() == 0) begin
            $error("unexpected beat: frame_byte %h byte_index %0d", rsp_tdata[7:0],
                   rsp_tdata[10:8]);
            mismatch_count++;
         end else begin
            want = frame_expect.pop_front();
            if (rsp_tdata[7:0] !== want.frame_byte) begin
               $error("frame_byte: expected %h, got %h", want.frame_byte, rsp_tdata[7:0]);
               mismatch_count++;
            end
            if (rsp_tdata[10:8] !== want.byte_index) begin
               $error("byte_index: expected %0d, got %0d", want.byte_index, rsp_tdata[10:8]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, rsp_tlast);
               mismatch_count++;
            end
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_taken != hold_asks) begin
         hold_taken = hold_asks;
         hold_left  = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no beat and no register access
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_reg(input ptzcf_pkg::reg_idx_type r, input logic [31:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (r == ptzcf_pkg::REG_CAM_ADDR) cam_addr_cfg = v[7:0];
      else dflt_pct_cfg = v[6:0];
      csr_writes++;
   endtask

   task automatic queue_cmd(input logic [4:0] op, input logic [7:0] param);
      cmd_beat_type c;
      c.op    = op;
      c.param = param;
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   task automatic wait_drained();
      while (cmds_accepted != cmds_queued || frame_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_param();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'd0;
         3:       return 8'd255;
         4:       return 8'($urandom_range(99, 101));
         5:       return 8'($urandom_range(1, 15));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_phase(input logic [7:0] addr, input logic [6:0] pct, input bit idling,
                            input bit long_hold, input int count);
      write_reg(ptzcf_pkg::REG_CAM_ADDR, {24'd0, addr});
      write_reg(ptzcf_pkg::REG_DFLT_PCT, {25'd0, pct});
      idle_on = idling;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) queue_cmd(5'($urandom_range(23, 31)), pick_param());
         else queue_cmd(5'($urandom_range(0, 22)), pick_param());
      end
      if (long_hold) hold_asks++;
      wait_drained();
   endtask

   initial begin
      logic [7:0] dir_params [0:7];
      dir_params = '{8'd0, 8'd255, 8'd100, 8'd99, 8'd1, 8'd14, 8'd15, 8'd86};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every operation at reset settings, speed extremes and preset nibbles
      for (int op = 0; op <= 22; op++) queue_cmd(5'(op), dir_params[op % 8]);
      queue_cmd(ptzcf_pkg::OP_PRESET_GOTO, 8'hFF);
      queue_cmd(ptzcf_pkg::OP_NONE, 8'hFF);
      queue_cmd(OP_UNUSED_TOP, 8'h00);
      wait_drained();

      run_phase(8'd0, 7'd0, 1'b1, 1'b0, 56);
      run_phase(8'd255, 7'd100, 1'b1, 1'b1, 56);
      run_phase(8'($urandom_range(0, 255)), 7'd99, 1'b1, 1'b0, 56);
      run_phase(8'($urandom_range(0, 255)), 7'($urandom_range(0, 100)), 1'b0, 1'b0, 56);
      run_phase(8'($urandom_range(0, 255)), 7'd1, 1'b1, 1'b0, 56);
      run_phase(8'd1, 7'd86, 1'b0, 1'b0, 56);

      $display("%0d commands accepted, %0d frame beats checked, %0d register writes",
               cmds_accepted, beats_checked, csr_writes);
      $display("covered all operations, speed saturation, osd, preset and silent codes");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/ptzcf_pkg.sv
src/ptzcf_front.sv
src/ptzcf_queue.sv
src/ptzcf_back.sv
src/ptz_camera_command_framer.sv
verif/ptz_camera_command_framer_test.sv
